// ----- rtl/tun_pkg.sv -----
// tun_pkg: shared constants and types of the triangle unit normal block.
// Used by every module in rtl but tun_front; depends on nothing.
package tun_pkg;
    localparam int OUT_W   = 32;
    localparam int QDEPTH  = 16;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int QCNT_W  = QADDR_W + 1;

    // stage control shared by the back pipelines
    typedef struct packed {
        logic advance;
        logic valid;
    } t_pipe_ctl;
endpackage

// ----- rtl/tun_front.sv -----
// tun_front: front pipeline, edges, cross product, magnitudes and |c|^2.
// Seven stages, never stalls; depends on no package items.
module tun_front #(
    parameter int W     = 24,
    parameter int MAG_W = 2 * W + 1,
    parameter int SQ_W  = 4 * W + 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [W-1:0]     i_v1_x,
    input  logic signed [W-1:0]     i_v1_y,
    input  logic signed [W-1:0]     i_v1_z,
    input  logic signed [W-1:0]     i_v2_x,
    input  logic signed [W-1:0]     i_v2_y,
    input  logic signed [W-1:0]     i_v2_z,
    input  logic signed [W-1:0]     i_v3_x,
    input  logic signed [W-1:0]     i_v3_y,
    input  logic signed [W-1:0]     i_v3_z,
    output logic                    o_valid,
    output logic [2:0][MAG_W-1:0]   o_mag,
    output logic [2:0]              o_neg,
    output logic                    o_zero,
    output logic [SQ_W-1:0]         o_sq
);
    localparam int EW   = W + 1;
    localparam int PW   = 2 * W + 2;
    localparam int LO_W = (MAG_W + 1) / 2;
    localparam int HI_W = MAG_W - LO_W;

    logic signed [W-1:0]   v1 [3];
    logic signed [W-1:0]   v2 [3];
    logic signed [W-1:0]   v3 [3];
    logic [6:0]            r_vld;
    logic signed [EW-1:0]  r_e1 [3];
    logic signed [EW-1:0]  r_e2 [3];
    logic signed [PW-1:0]  r_pa [3];
    logic signed [PW-1:0]  r_pb [3];
    logic signed [PW-1:0]  r_c  [3];
    logic [2:0][MAG_W-1:0] r_mag4, r_mag5, r_mag6, r_mag7;
    logic [2:0]            r_neg4, r_neg5, r_neg6, r_neg7;
    logic                  r_zero4, r_zero5, r_zero6, r_zero7;
    logic [2*HI_W-1:0]     r_hh [3];
    logic [MAG_W-1:0]      r_hl [3];
    logic [2*LO_W-1:0]     r_ll [3];
    logic [2*MAG_W-1:0]    r_sqr [3];
    logic [SQ_W-1:0]       r_sq;

    assign v1[0] = i_v1_x;  assign v1[1] = i_v1_y;  assign v1[2] = i_v1_z;
    assign v2[0] = i_v2_x;  assign v2[1] = i_v2_y;  assign v2[2] = i_v2_z;
    assign v3[0] = i_v3_x;  assign v3[1] = i_v3_y;  assign v3[2] = i_v3_z;

    // advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    // per axis: edges, products, cross component, magnitude, square
    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_e1[k]  <= EW'(v2[k]) - EW'(v1[k]);
            r_e2[k]  <= EW'(v3[k]) - EW'(v1[k]);
            r_pa[k]  <= r_e1[K1] * r_e2[K2];
            r_pb[k]  <= r_e1[K2] * r_e2[K1];
            r_c[k]   <= r_pa[k] - r_pb[k];
            r_neg4[k] <= r_c[k][PW-1];
            r_mag4[k] <= r_c[k][PW-1] ? MAG_W'(-r_c[k]) : MAG_W'(r_c[k]);
            r_hh[k]  <= r_mag4[k][MAG_W-1:LO_W] * r_mag4[k][MAG_W-1:LO_W];
            r_hl[k]  <= r_mag4[k][MAG_W-1:LO_W] * r_mag4[k][LO_W-1:0];
            r_ll[k]  <= r_mag4[k][LO_W-1:0] * r_mag4[k][LO_W-1:0];
            r_sqr[k] <= {r_hh[k], r_ll[k]} + ((2 * MAG_W)'(r_hl[k]) << (LO_W + 1));
        end
    end

    // sum the squares, carry magnitudes and flags alongside
    always_ff @(posedge i_clk) begin
        r_zero4 <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        r_mag5  <= r_mag4;  r_neg5 <= r_neg4;  r_zero5 <= r_zero4;
        r_mag6  <= r_mag5;  r_neg6 <= r_neg5;  r_zero6 <= r_zero5;
        r_mag7  <= r_mag6;  r_neg7 <= r_neg6;  r_zero7 <= r_zero6;
        r_sq    <= SQ_W'(r_sqr[0]) + SQ_W'(r_sqr[1]) + SQ_W'(r_sqr[2]);
    end

    assign o_valid = r_vld[6];
    assign o_mag   = r_mag7;
    assign o_neg   = r_neg7;
    assign o_zero  = r_zero7;
    assign o_sq    = r_sq;
endmodule

// ----- rtl/tun_queue.sv -----
// tun_queue: small register FIFO between front and back pipelines.
// Depends on tun_pkg for depth and pointer widths.
module tun_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);
    import tun_pkg::*;

    logic [DW-1:0]      r_mem [QDEPTH];
    logic [QADDR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    // hold pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // write storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
endmodule

// ----- rtl/tun_sqrt.sv -----
// tun_sqrt: pipelined integer square root of sq * 2^(2F), one root bit
// per stage. Depends on tun_pkg for the stage control type.
module tun_sqrt #(
    parameter int SQ_W = 100,
    parameter int F    = 30,
    parameter int SB_W = 8,
    parameter int M_W  = SQ_W / 2 + F
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tun_pkg::t_pipe_ctl i_ctl,
    input  logic [SQ_W-1:0]    i_sq,
    input  logic [SB_W-1:0]    i_sb,
    output logic               o_valid,
    output logic [M_W-1:0]     o_root,
    output logic [SB_W-1:0]    o_sb
);
    import tun_pkg::*;

    logic [M_W+1:0]  r_rem  [M_W];
    logic [M_W-1:0]  r_root [M_W];
    logic [SQ_W-1:0] r_n    [M_W];
    logic [SB_W-1:0] r_sb   [M_W];
    logic [M_W-1:0]  r_vld;

    for (genvar s = 0; s < M_W; s++) begin : g_stage
        logic [M_W+1:0]  a_rem, rem_sh, trial, n_rem;
        logic [M_W-1:0]  a_root, n_root;
        logic [SQ_W-1:0] a_n;
        logic [SB_W-1:0] a_sb;
        logic            a_vld, ge;
        if (s == 0) begin : g_first
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_n    = i_sq;
            assign a_sb   = i_sb;
            assign a_vld  = i_ctl.valid;
        end else begin : g_next
            assign a_rem  = r_rem[s-1];
            assign a_root = r_root[s-1];
            assign a_n    = r_n[s-1];
            assign a_sb   = r_sb[s-1];
            assign a_vld  = r_vld[s-1];
        end
        // bring down two bits, try root bit one
        assign rem_sh = {a_rem[M_W-1:0], a_n[SQ_W-1 -: 2]};
        assign trial  = {a_root, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign n_rem  = ge ? rem_sh - trial : rem_sh;
        assign n_root = {a_root[M_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.advance) begin
                r_vld[s]  <= a_vld;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_n[s]    <= {a_n[SQ_W-3:0], 2'b00};
                r_sb[s]   <= a_sb;
            end
        end
    end

    assign o_valid = r_vld[M_W-1];
    assign o_root  = r_root[M_W-1];
    assign o_sb    = r_sb[M_W-1];
endmodule

// ----- rtl/tun_div.sv -----
// tun_div: pipelined restoring divider, one quotient bit per stage.
// Depends on tun_pkg for the stage control type.
module tun_div #(
    parameter int M_W  = 80,
    parameter int Q_W  = 32,
    parameter int SB_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tun_pkg::t_pipe_ctl i_ctl,
    input  logic [M_W:0]       i_num,
    input  logic [M_W-1:0]     i_den,
    input  logic [SB_W-1:0]    i_sb,
    output logic               o_valid,
    output logic [Q_W-1:0]     o_quo,
    output logic [SB_W-1:0]    o_sb
);
    import tun_pkg::*;

    logic [M_W:0]    r_rem [Q_W];
    logic [M_W-1:0]  r_den [Q_W];
    logic [Q_W-1:0]  r_quo [Q_W];
    logic [SB_W-1:0] r_sb  [Q_W];
    logic [Q_W-1:0]  r_vld;

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [M_W:0]    a_rem, rem_sh, n_rem;
        logic [M_W-1:0]  a_den;
        logic [Q_W-1:0]  a_quo;
        logic [SB_W-1:0] a_sb;
        logic            a_vld, ge;
        if (s == 0) begin : g_first
            assign a_rem = i_num;
            assign a_den = i_den;
            assign a_quo = '0;
            assign a_sb  = i_sb;
            assign a_vld = i_ctl.valid;
        end else begin : g_next
            assign a_rem = r_rem[s-1];
            assign a_den = r_den[s-1];
            assign a_quo = r_quo[s-1];
            assign a_sb  = r_sb[s-1];
            assign a_vld = r_vld[s-1];
        end
        // shift in a zero, subtract when the divisor fits
        assign rem_sh = {a_rem[M_W-1:0], 1'b0};
        assign ge     = (rem_sh >= {1'b0, a_den});
        assign n_rem  = ge ? rem_sh - {1'b0, a_den} : rem_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.advance) begin
                r_vld[s] <= a_vld;
                r_rem[s] <= n_rem;
                r_den[s] <= a_den;
                r_quo[s] <= {a_quo[Q_W-2:0], ge};
                r_sb[s]  <= a_sb;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];
endmodule

// ----- rtl/triangle_unit_normal.sv -----
// triangle_unit_normal: top level, front pipeline, queue, square root and
// three dividers. Depends on tun_pkg, tun_front, tun_queue, tun_sqrt, tun_div.
//
// Unit face normal of a triangle. One triangle is accepted per cycle and one
// result leaves per cycle when the output side keeps ready high. A triangle
// passes 7 front stages, the queue, 2*COORD_WIDTH+2+NORMAL_FRAC_BITS square
// root stages (one root bit each) and NORMAL_FRAC_BITS+2 divider stages (one
// quotient bit each). The front never stalls; a 16-entry queue absorbs
// output backpressure, and input ready drops once 16 triangles sit in the
// front and queue together. A zero cross product gives a zero normal with
// degenerate set.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]  i_v1_x,
    input  logic signed [COORD_WIDTH-1:0]  i_v1_y,
    input  logic signed [COORD_WIDTH-1:0]  i_v1_z,
    input  logic signed [COORD_WIDTH-1:0]  i_v2_x,
    input  logic signed [COORD_WIDTH-1:0]  i_v2_y,
    input  logic signed [COORD_WIDTH-1:0]  i_v2_z,
    input  logic signed [COORD_WIDTH-1:0]  i_v3_x,
    input  logic signed [COORD_WIDTH-1:0]  i_v3_y,
    input  logic signed [COORD_WIDTH-1:0]  i_v3_z,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [tun_pkg::OUT_W-1:0] o_normal_x,
    output logic signed [tun_pkg::OUT_W-1:0] o_normal_y,
    output logic signed [tun_pkg::OUT_W-1:0] o_normal_z,
    output logic                           o_degenerate
);
    import tun_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int MAG_W = 2 * W + 1;
    localparam int SQ_W  = 4 * W + 4;
    localparam int M_W   = SQ_W / 2 + F;
    localparam int Q_W   = F + 2;
    localparam int SB_W  = 4 + 3 * MAG_W;
    localparam int DW    = SQ_W + SB_W;
    localparam logic [Q_W-1:0] UNIT_Q = Q_W'(1) << F;
    localparam logic signed [OUT_W-1:0] UNIT_O = OUT_W'(1) << F;

    logic                  accept, pop, advance;
    logic [QCNT_W-1:0]     r_cnt;
    logic                  f_valid, f_zero;
    logic [2:0][MAG_W-1:0] f_mag;
    logic [2:0]            f_neg;
    logic [SQ_W-1:0]       f_sq;
    logic [DW-1:0]         q_data;
    logic                  q_empty;
    t_pipe_ctl             sqrt_ctl, div_ctl;
    logic                  s_valid;
    logic [M_W-1:0]        s_root;
    logic [SB_W-1:0]       s_sb;
    logic [2:0][MAG_W-1:0] s_mag;
    logic [2:0]            s_neg;
    logic                  s_zero;
    logic [M_W:0]          num [3];
    logic [2:0]            d_valid;
    logic [Q_W-1:0]        d_quo [3];
    logic [1:0]            d_sb_x;
    logic                  d_sb_y, d_sb_z;
    logic [2:0]            out_neg;
    logic signed [OUT_W-1:0] out_val [3];

    // admit triangles while the front and queue have room
    assign o_in_ready = (r_cnt < QCNT_W'(QDEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = !d_valid[0] || i_out_ready;
    assign pop        = advance && !q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + QCNT_W'(accept) - QCNT_W'(pop);
        end
    end

    tun_front #(.W(W), .MAG_W(MAG_W), .SQ_W(SQ_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_v1_x(i_v1_x), .i_v1_y(i_v1_y), .i_v1_z(i_v1_z),
        .i_v2_x(i_v2_x), .i_v2_y(i_v2_y), .i_v2_z(i_v2_z),
        .i_v3_x(i_v3_x), .i_v3_y(i_v3_y), .i_v3_z(i_v3_z),
        .o_valid(f_valid), .o_mag(f_mag), .o_neg(f_neg),
        .o_zero(f_zero), .o_sq(f_sq)
    );

    tun_queue #(.DW(DW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_valid), .i_data({f_zero, f_neg, f_mag, f_sq}),
        .i_pop(pop), .o_data(q_data), .o_empty(q_empty)
    );

    assign sqrt_ctl.advance = advance;
    assign sqrt_ctl.valid   = !q_empty;

    tun_sqrt #(.SQ_W(SQ_W), .F(F), .SB_W(SB_W), .M_W(M_W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(sqrt_ctl),
        .i_sq(q_data[SQ_W-1:0]), .i_sb(q_data[DW-1:SQ_W]),
        .o_valid(s_valid), .o_root(s_root), .o_sb(s_sb)
    );

    assign {s_zero, s_neg, s_mag} = s_sb;
    assign div_ctl.advance = advance;
    assign div_ctl.valid   = s_valid;

    // initial remainder: |c| * 2^(F-2), the top of |c| * 2^(2F)
    for (genvar k = 0; k < 3; k++) begin : g_num
        assign num[k] = (M_W + 1)'({s_mag[k], {(F - 2){1'b0}}});
    end

    tun_div #(.M_W(M_W), .Q_W(Q_W), .SB_W(2)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
        .i_num(num[0]), .i_den(s_root), .i_sb({s_zero, s_neg[0]}),
        .o_valid(d_valid[0]), .o_quo(d_quo[0]), .o_sb(d_sb_x)
    );
    tun_div #(.M_W(M_W), .Q_W(Q_W), .SB_W(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
        .i_num(num[1]), .i_den(s_root), .i_sb(s_neg[1]),
        .o_valid(d_valid[1]), .o_quo(d_quo[1]), .o_sb(d_sb_y)
    );
    tun_div #(.M_W(M_W), .Q_W(Q_W), .SB_W(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_ctl),
        .i_num(num[2]), .i_den(s_root), .i_sb(s_neg[2]),
        .o_valid(d_valid[2]), .o_quo(d_quo[2]), .o_sb(d_sb_z)
    );

    // saturate to one, apply sign, drop to zero for a degenerate triangle
    assign out_neg = {d_sb_z, d_sb_y, d_sb_x[0]};
    for (genvar k = 0; k < 3; k++) begin : g_out
        logic [Q_W-1:0]          sat;
        logic signed [OUT_W-1:0] ext;
        assign sat = (d_quo[k] > UNIT_Q) ? UNIT_Q : d_quo[k];
        assign ext = OUT_W'(sat);
        assign out_val[k] = d_sb_x[1] ? '0 : (out_neg[k] ? -ext : ext);
    end

    assign o_out_valid  = d_valid[0];
    assign o_normal_x   = out_val[0];
    assign o_normal_y   = out_val[1];
    assign o_normal_z   = out_val[2];
    assign o_degenerate = d_sb_x[1];

    // the credit count never exceeds the queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("credit count above queue depth");

    // the three divider lanes stay in step
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_valid[0] == d_valid[1]) && (d_valid[0] == d_valid[2]))
        else $error("divider lanes out of step");

    // a delivered x or z component lies within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_x <= UNIT_O) && (o_normal_x >= -UNIT_O)
                     && (o_normal_z <= UNIT_O) && (o_normal_z >= -UNIT_O))
        else $error("normal component out of range");
endmodule
